/* src/tfpg_pkg.sv */
// Types, constants and helper functions for the test frame payload generator.
package tfpg_pkg;

   localparam logic [15:0] MAX_PAYLOAD = 16'd512;

   localparam logic [31:0] SEED_MIX = 32'h6d2b_79f5;
   localparam logic [15:0] CRC_INIT = 16'hffff;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [31:0] LCG_MUL  = 32'd1664525;
   localparam logic [31:0] LCG_ADD  = 32'd1013904223;

   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

   localparam logic [2:0] PAT_ZERO = 3'd0;
   localparam logic [2:0] PAT_ONES = 3'd1;
   localparam logic [2:0] PAT_INCR = 3'd2;
   localparam logic [2:0] PAT_ALT  = 3'd3;
   localparam logic [2:0] PAT_LCG  = 3'd4;
   localparam logic [2:0] PAT_SLIP = 3'd5;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_LEN = 2'd1;
   localparam logic [1:0] STATUS_IDLE    = 2'd2;

   localparam logic [2:0] SLIP_LAST = 3'd5;

   typedef struct packed {
      logic        opcode;
      logic [31:0] sequence_number;
      logic [15:0] payload_len;
      logic [2:0]  pattern;
   } req_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        byte_valid;
      logic [15:0] crc_value;
      logic        last;
      logic [1:0]  status;
   } rsp_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [31:0] lcg_step(input logic [31:0] s);
      logic [31:0] p;
      p = s * LCG_MUL;
      return p + LCG_ADD;
   endfunction

   function automatic logic [7:0] slip_byte(input logic [2:0] phase);
      logic [7:0] b;
      unique case (phase)
         3'd1:    b = 8'hff;
         3'd2:    b = 8'haa;
         3'd3:    b = 8'h55;
         3'd4:    b = 8'hc0;
         3'd5:    b = 8'hdb;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* src/tfpg_req_if.sv */
// Request channel interface: valid, ready and the request payload.
interface tfpg_req_if;
   logic               valid;
   logic               ready;
   tfpg_pkg::req_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* src/tfpg_rsp_if.sv */
// Response channel interface: valid, ready and the response payload.
interface tfpg_rsp_if;
   logic               valid;
   logic               ready;
   tfpg_pkg::rsp_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* src/test_frame_payload_generator.sv */
// Top level: test frame payload generator with running CRC-16/CCITT.
// A response is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while responses are taken; the output register frees as it is taken.
// The next LCG value is kept precomputed so the multiply sits alone in its path.
// Synchronous active-high reset clears all frame state (CRC to 0xFFFF) at once.
module test_frame_payload_generator (
   input  logic              clock,
   input  logic              reset,
   tfpg_req_if.sink          req_ch,
   tfpg_rsp_if.source        rsp_ch
);

   logic [31:0]        seed_ff, seed_in;
   logic [31:0]        seed_next_ff, seed_next_in;
   logic [2:0]         pattern_ff, pattern_in;
   logic [15:0]        byte_index_ff, byte_index_in;
   logic [15:0]        frame_len_ff, frame_len_in;
   logic [2:0]         slip_phase_ff, slip_phase_in;
   logic [15:0]        crc_ff, crc_in;
   logic               active_ff, active_in;
   logic               rsp_valid_ff, rsp_valid_in;
   tfpg_pkg::rsp_type  rsp_ff, rsp_in;

   logic               accept;
   logic [7:0]         byte_w;
   logic [7:0]         incr_w;
   logic [15:0]        crc_new;
   logic [15:0]        index_inc;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_ff;

   assign incr_w    = seed_ff[7:0] + byte_index_ff[7:0];
   assign index_inc = byte_index_ff + 16'd1;

   always_comb begin
      unique case (pattern_ff)
         tfpg_pkg::PAT_ZERO: byte_w = 8'h00;
         tfpg_pkg::PAT_ONES: byte_w = 8'hff;
         tfpg_pkg::PAT_INCR: byte_w = incr_w;
         tfpg_pkg::PAT_ALT:  byte_w = byte_index_ff[0] ? 8'h55 : 8'haa;
         tfpg_pkg::PAT_LCG:  byte_w = seed_next_ff[31:24];
         tfpg_pkg::PAT_SLIP: byte_w = tfpg_pkg::slip_byte(slip_phase_ff);
         default:            byte_w = 8'h00;
      endcase
   end

   assign crc_new = tfpg_pkg::crc_step(crc_ff, byte_w);

   always_comb begin
      seed_in       = seed_ff;
      seed_next_in  = seed_next_ff;
      pattern_in    = pattern_ff;
      byte_index_in = byte_index_ff;
      frame_len_in  = frame_len_ff;
      slip_phase_in = slip_phase_ff;
      crc_in        = crc_ff;
      active_in     = active_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;

      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (req_ch.data.opcode == tfpg_pkg::OP_START) begin
            crc_in = tfpg_pkg::CRC_INIT;
            if (req_ch.data.payload_len > tfpg_pkg::MAX_PAYLOAD) begin
               active_in     = 1'b0;
               rsp_in.status = tfpg_pkg::STATUS_BAD_LEN;
            end else begin
               seed_in       = req_ch.data.sequence_number ^ tfpg_pkg::SEED_MIX;
               seed_next_in  = tfpg_pkg::lcg_step(seed_in);
               pattern_in    = req_ch.data.pattern;
               byte_index_in = 16'd0;
               frame_len_in  = req_ch.data.payload_len;
               slip_phase_in = 3'd0;
               active_in     = (req_ch.data.payload_len != 16'd0);
               rsp_in.crc_value = tfpg_pkg::CRC_INIT;
               rsp_in.last      = (req_ch.data.payload_len == 16'd0);
               rsp_in.status    = tfpg_pkg::STATUS_OK;
            end
         end else if (!active_ff) begin
            rsp_in.crc_value = crc_ff;
            rsp_in.status    = tfpg_pkg::STATUS_IDLE;
         end else begin
            if (pattern_ff == tfpg_pkg::PAT_LCG) begin
               seed_in      = seed_next_ff;
               seed_next_in = tfpg_pkg::lcg_step(seed_next_ff);
            end
            if (pattern_ff == tfpg_pkg::PAT_SLIP) begin
               slip_phase_in = (slip_phase_ff >= tfpg_pkg::SLIP_LAST) ? 3'd0
                                                                      : slip_phase_ff + 3'd1;
            end
            crc_in        = crc_new;
            byte_index_in = index_inc;
            rsp_in.payload_byte = byte_w;
            rsp_in.byte_valid   = 1'b1;
            rsp_in.crc_value    = crc_new;
            rsp_in.status       = tfpg_pkg::STATUS_OK;
            if (index_inc >= frame_len_ff) begin
               rsp_in.last = 1'b1;
               active_in   = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= 32'd0;
         seed_next_ff  <= tfpg_pkg::LCG_ADD;
         pattern_ff    <= 3'd0;
         byte_index_ff <= 16'd0;
         frame_len_ff  <= 16'd0;
         slip_phase_ff <= 3'd0;
         crc_ff        <= tfpg_pkg::CRC_INIT;
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         seed_ff       <= seed_in;
         seed_next_ff  <= seed_next_in;
         pattern_ff    <= pattern_in;
         byte_index_ff <= byte_index_in;
         frame_len_ff  <= frame_len_in;
         slip_phase_ff <= slip_phase_in;
         crc_ff        <= crc_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_byte_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.byte_valid) |-> (rsp_ff.status == tfpg_pkg::STATUS_OK))
      else $error("payload byte reported with non-ok status");

   a_idle_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == tfpg_pkg::STATUS_IDLE)
         |-> (!rsp_ff.byte_valid && !rsp_ff.last && rsp_ff.payload_byte == 8'h00))
      else $error("idle response carries frame data");

   a_index_bound : assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (byte_index_ff < frame_len_ff))
      else $error("active frame ran past its length");

   a_empty_last : assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.data.opcode == tfpg_pkg::OP_START && req_ch.data.payload_len == 16'd0)
         |=> (rsp_valid_ff && rsp_ff.last && !active_ff))
      else $error("empty frame start not flagged last");

   a_seed_lookahead : assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.data.opcode == tfpg_pkg::OP_NEXT && active_ff
         && pattern_ff == tfpg_pkg::PAT_LCG) |=> (seed_ff == $past(seed_next_ff)))
      else $error("LCG seed did not advance to precomputed value");
`endif

endmodule

/* tb/tb_test_frame_payload_generator.sv */
// Self-checking testbench for the test frame payload generator: directed and random frames.
module tb_test_frame_payload_generator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLOCK_PERIOD  = 20;
   localparam int          RESET_CYCLES  = 4;
   localparam int          RANDOM_ITEMS  = 1700;
   localparam int          DRAIN_CYCLES  = 5;
   localparam int          LIMIT_CYCLES  = 500000;
   localparam int          MAX_SHOWN     = 10;
   localparam int          MAX_BIG       = 3;
   localparam logic [7:0]  SLIP_SEQ [6]  = '{8'h00, 8'hff, 8'haa, 8'h55, 8'hc0, 8'hdb};

   class frame_byte_tracker;
      logic [31:0]        seed_q;
      logic [2:0]         pattern_q;
      logic [15:0]        index_q;
      logic [15:0]        length_q;
      logic [2:0]         slip_q;
      logic [15:0]        crc_q;
      logic               open_q;
      tfpg_pkg::rsp_type  awaited_rsp [$];
      int                 mismatches;
      int                 frames;
      int                 rejected;
      int                 idle_replies;
      int                 bytes_checked;

      function new();
         seed_q        = '0;
         pattern_q     = '0;
         index_q       = '0;
         length_q      = '0;
         slip_q        = '0;
         crc_q         = tfpg_pkg::CRC_INIT;
         open_q        = 1'b0;
         mismatches    = 0;
         frames        = 0;
         rejected      = 0;
         idle_replies  = 0;
         bytes_checked = 0;
      endfunction

      function logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
         logic [15:0] c;
         c = crc;
         for (int i = 7; i >= 0; i--) begin
            c = {c[14:0], 1'b0} ^ ((c[15] ^ b[i]) ? tfpg_pkg::CRC_POLY : 16'h0000);
         end
         return c;
      endfunction

      function void note_request(input tfpg_pkg::req_type r);
         tfpg_pkg::rsp_type  e;
         logic [7:0]         b;
         e = '0;
         if (r.opcode == tfpg_pkg::OP_START) begin
            if (r.payload_len > tfpg_pkg::MAX_PAYLOAD) begin
               open_q   = 1'b0;
               crc_q    = tfpg_pkg::CRC_INIT;
               e.status = tfpg_pkg::STATUS_BAD_LEN;
               rejected++;
            end else begin
               seed_q      = r.sequence_number ^ tfpg_pkg::SEED_MIX;
               pattern_q   = r.pattern;
               index_q     = '0;
               length_q    = r.payload_len;
               slip_q      = '0;
               crc_q       = tfpg_pkg::CRC_INIT;
               open_q      = (r.payload_len != 16'd0);
               e.crc_value = tfpg_pkg::CRC_INIT;
               e.last      = (r.payload_len == 16'd0);
               e.status    = tfpg_pkg::STATUS_OK;
               frames++;
            end
         end else if (!open_q) begin
            e.crc_value = crc_q;
            e.status    = tfpg_pkg::STATUS_IDLE;
            idle_replies++;
         end else begin
            case (pattern_q)
               tfpg_pkg::PAT_ONES: b = 8'hff;
               tfpg_pkg::PAT_INCR: b = seed_q[7:0] + index_q[7:0];
               tfpg_pkg::PAT_ALT:  b = index_q[0] ? 8'h55 : 8'haa;
               tfpg_pkg::PAT_LCG: begin
                  seed_q = seed_q * tfpg_pkg::LCG_MUL + tfpg_pkg::LCG_ADD;
                  b      = seed_q[31:24];
               end
               tfpg_pkg::PAT_SLIP: begin
                  b      = SLIP_SEQ[slip_q];
                  slip_q = (slip_q == tfpg_pkg::SLIP_LAST) ? 3'd0 : slip_q + 3'd1;
               end
               default:  b = 8'h00;
            endcase
            crc_q          = crc_fold(crc_q, b);
            index_q        = index_q + 16'd1;
            e.payload_byte = b;
            e.byte_valid   = 1'b1;
            e.crc_value    = crc_q;
            e.status       = tfpg_pkg::STATUS_OK;
            if (index_q >= length_q) begin
               e.last = 1'b1;
               open_q = 1'b0;
            end
         end
         awaited_rsp.push_back(e);
      endfunction

      function void check_response(input tfpg_pkg::rsp_type got);
         tfpg_pkg::rsp_type want;
         if (awaited_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
               $display("%0t: unexpected response %p", $realtime, got);
            end
            return;
         end
         want = awaited_rsp.pop_front();
         if (want.byte_valid) begin
            bytes_checked++;
         end
         if (got.payload_byte !== want.payload_byte || got.byte_valid !== want.byte_valid ||
             got.crc_value !== want.crc_value || got.last !== want.last ||
             got.status !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
               $display("%0t: mismatch byte %h/%h valid %b/%b crc %h/%h last %b/%b status %0d/%0d",
                        $realtime, want.payload_byte, got.payload_byte, want.byte_valid,
                        got.byte_valid, want.crc_value, got.crc_value, want.last, got.last,
                        want.status, got.status);
            end
         end
      endfunction

      function int outstanding();
         return awaited_rsp.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   int                 cycle_count;
   int                 sent_count;
   bit                 tx_quiet;
   frame_byte_tracker  tracker;

   tfpg_req_if req_ch ();
   tfpg_rsp_if rsp_ch ();

   test_frame_payload_generator i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("Timeout after %0d cycles with %0d responses outstanding", cycle_count,
               tracker.outstanding());
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_ch.valid && req_ch.ready) begin
         tracker.note_request(req_ch.data);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_response(rsp_ch.data);
      end
   end

   initial begin
      int unsigned hold;
      int unsigned k;
      logic        level;
      hold  = 0;
      level = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold == 0) begin
            k = $urandom_range(0, 99);
            if (k < 20) begin
               level = 1'b1;
               hold  = $urandom_range(20, 80);
            end else if (k < 60) begin
               level = 1'b1;
               hold  = $urandom_range(1, 4);
            end else if (k < 92) begin
               level = 1'b0;
               hold  = $urandom_range(1, 3);
            end else begin
               level = 1'b0;
               hold  = $urandom_range(4, 25);
            end
         end
         rsp_ch.ready <= level;
         hold--;
         @(posedge clock);
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned k;
      if (tx_quiet) begin
         return 0;
      end
      k = $urandom_range(0, 99);
      if (k < 60) begin
         return 0;
      end else if (k < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 25);
   endfunction

   task automatic send_request(input tfpg_pkg::req_type r);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic start_frame(input logic [31:0] seq, input logic [15:0] len,
                              input logic [2:0] pat);
      tfpg_pkg::req_type r;
      r.opcode          = tfpg_pkg::OP_START;
      r.sequence_number = seq;
      r.payload_len     = len;
      r.pattern         = pat;
      send_request(r);
   endtask

   task automatic pull_byte();
      tfpg_pkg::req_type r;
      r.opcode          = tfpg_pkg::OP_NEXT;
      r.sequence_number = $urandom;
      r.payload_len     = 16'($urandom_range(0, 65535));
      r.pattern         = 3'($urandom_range(0, 7));
      send_request(r);
   endtask

   task automatic run_random_frames();
      int unsigned k;
      int unsigned len;
      int unsigned pulls;
      int          big_frames;
      big_frames = 0;
      while (sent_count < RANDOM_ITEMS) begin
         tx_quiet = ($urandom_range(0, 3) == 0);
         k = $urandom_range(0, 99);
         if (k < 4) begin
            len = $urandom_range(tfpg_pkg::MAX_PAYLOAD + 1, 65535);
         end else if (k < 8) begin
            len = 0;
         end else if (k < 10 && big_frames < MAX_BIG) begin
            len = 32'(tfpg_pkg::MAX_PAYLOAD);
            big_frames++;
         end else begin
            len = $urandom_range(1, 24);
         end
         start_frame($urandom, len[15:0], 3'($urandom_range(0, 7)));
         pulls = (len > tfpg_pkg::MAX_PAYLOAD) ? $urandom_range(0, 2) : len;
         if (len <= tfpg_pkg::MAX_PAYLOAD && len != 0 && $urandom_range(0, 4) == 0) begin
            pulls = $urandom_range(0, len);
         end else if ($urandom_range(0, 3) == 0) begin
            pulls += $urandom_range(1, 2);
         end
         repeat (pulls) pull_byte();
      end
   endtask

   initial begin
      tracker    = new();
      sent_count = 0;
      tx_quiet   = 1'b0;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      pull_byte();
      start_frame(32'h0000_0000, tfpg_pkg::MAX_PAYLOAD + 16'd1, tfpg_pkg::PAT_ZERO);
      start_frame(32'hffff_ffff, 16'hffff, tfpg_pkg::PAT_LCG);
      pull_byte();
      start_frame(32'h0000_0000, 16'd0, tfpg_pkg::PAT_ZERO);
      pull_byte();
      start_frame(32'h1234_5678, 16'd1, tfpg_pkg::PAT_ONES);
      pull_byte();
      start_frame(32'hffff_ffff, 16'd2, tfpg_pkg::PAT_INCR);
      repeat (2) pull_byte();
      start_frame(32'h8000_0001, 16'd2, tfpg_pkg::PAT_ALT);
      repeat (2) pull_byte();
      start_frame(32'h6d2b_79f5, 16'd2, tfpg_pkg::PAT_LCG);
      repeat (2) pull_byte();
      start_frame(32'h0f0f_0f0f, 16'd7, tfpg_pkg::PAT_SLIP);
      repeat (7) pull_byte();
      start_frame(32'h0000_0001, 16'd2, 3'd6);
      pull_byte();
      start_frame(32'hdead_beef, 16'd1, 3'd7);
      pull_byte();

      run_random_frames();
      req_ch.valid <= 1'b0;

      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d frames opened, %0d rejected, %0d idle replies,",
               sent_count, tracker.frames, tracker.rejected, tracker.idle_replies);
      $display("%0d payload bytes checked over all patterns, %0d mismatches",
               tracker.bytes_checked, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
